@@ hdl/polygon_convexity_checker_top_defines.svh @@
// assertion macros for the polygon convexity checker
// used by the port-level checker; expects aclk and aresetn in scope
`ifndef POLYGON_CONVEXITY_CHECKER_TOP_DEFINES_SVH
`define POLYGON_CONVEXITY_CHECKER_TOP_DEFINES_SVH

// antecedent holds, consequent must hold in the next cycle
`define PCC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// antecedent holds, consequent must hold in the same cycle
`define PCC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ hdl/pcc_pkg.sv @@
// shared types and constants for the polygon convexity checker
// no dependencies
package pcc_pkg;

    // default coordinate width used inside the datapath
    localparam int COORD_BITS_DEF = 16;

    // stream field widths
    localparam int VERTEX_W  = 16;
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 8;

    // vertex count codes, saturating at three
    localparam logic [1:0] CNT_EMPTY = 2'd0;
    localparam logic [1:0] CNT_ONE   = 2'd1;
    localparam logic [1:0] CNT_TWO   = 2'd2;
    localparam logic [1:0] CNT_MANY  = 2'd3;

    // per-vertex control carried down the pipeline
    typedef struct packed {
        logic [1:0] seen;     // vertices seen before this one
        logic       closing;  // final vertex of the polygon
    } ctrl_t;

endpackage

@@ hdl/pcc_edge_stage.sv @@
// input register, edge differences and polygon vertex/edge state
// depends on pcc_pkg
module pcc_edge_stage #(
    parameter int COORD_BITS = pcc_pkg::COORD_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [COORD_BITS-1:0]       in_x,
    input  logic [COORD_BITS-1:0]       in_y,
    input  logic                        in_last,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [COORD_BITS:0]  pe_x,
    output logic signed [COORD_BITS:0]  pe_y,
    output logic signed [COORD_BITS:0]  e_x,
    output logic signed [COORD_BITS:0]  e_y,
    output logic signed [COORD_BITS:0]  c_x,
    output logic signed [COORD_BITS:0]  c_y,
    output logic signed [COORD_BITS:0]  fe_x,
    output logic signed [COORD_BITS:0]  fe_y,
    output pcc_pkg::ctrl_t              out_ctrl
);

    localparam int EW = COORD_BITS + 1;

    // input register
    logic                  s1_valid_reg;
    logic [COORD_BITS-1:0] s1_x_reg, s1_y_reg;
    logic                  s1_last_reg;

    // polygon state
    logic [COORD_BITS-1:0] first_x_reg, first_y_reg, first_x_next, first_y_next;
    logic [COORD_BITS-1:0] prev_x_reg, prev_y_reg, prev_x_next, prev_y_next;
    logic signed [EW-1:0]  first_ex_reg, first_ey_reg, first_ex_next, first_ey_next;
    logic signed [EW-1:0]  prev_ex_reg, prev_ey_reg, prev_ex_next, prev_ey_next;
    logic [1:0]            cnt_reg, cnt_next;

    // operand register
    logic                  s2_valid_reg;
    logic signed [EW-1:0]  pe_x_reg, pe_y_reg, e_x_reg, e_y_reg;
    logic signed [EW-1:0]  c_x_reg, c_y_reg, fe_x_reg, fe_y_reg;
    pcc_pkg::ctrl_t        ctrl_reg;

    logic                  en1, en2, take;
    logic signed [EW-1:0]  ex, ey, cx, cy;

    // stage enables
    assign en2      = !s2_valid_reg || out_ready;
    assign en1      = !s1_valid_reg || en2;
    assign in_ready = en1;
    assign take     = s1_valid_reg && en2;

    // new edge and closing edge back to the first vertex
    assign ex = $signed({1'b0, s1_x_reg}) - $signed({1'b0, prev_x_reg});
    assign ey = $signed({1'b0, s1_y_reg}) - $signed({1'b0, prev_y_reg});
    assign cx = $signed({1'b0, first_x_reg}) - $signed({1'b0, s1_x_reg});
    assign cy = $signed({1'b0, first_y_reg}) - $signed({1'b0, s1_y_reg});

    // state update for the vertex leaving the input register
    always_comb begin
        first_x_next  = first_x_reg;
        first_y_next  = first_y_reg;
        prev_x_next   = prev_x_reg;
        prev_y_next   = prev_y_reg;
        first_ex_next = first_ex_reg;
        first_ey_next = first_ey_reg;
        prev_ex_next  = prev_ex_reg;
        prev_ey_next  = prev_ey_reg;
        cnt_next      = cnt_reg;
        if (take) begin
            if (cnt_reg == pcc_pkg::CNT_EMPTY) begin
                first_x_next = s1_x_reg;
                first_y_next = s1_y_reg;
            end
            if (cnt_reg == pcc_pkg::CNT_ONE) begin
                first_ex_next = ex;
                first_ey_next = ey;
            end
            if (cnt_reg != pcc_pkg::CNT_EMPTY) begin
                prev_ex_next = ex;
                prev_ey_next = ey;
            end
            prev_x_next = s1_x_reg;
            prev_y_next = s1_y_reg;
            if (cnt_reg != pcc_pkg::CNT_MANY) begin
                cnt_next = cnt_reg + 2'd1;
            end
            // a closed polygon leaves the block empty
            if (s1_last_reg) begin
                first_x_next  = '0;
                first_y_next  = '0;
                prev_x_next   = '0;
                prev_y_next   = '0;
                first_ex_next = '0;
                first_ey_next = '0;
                prev_ex_next  = '0;
                prev_ey_next  = '0;
                cnt_next      = pcc_pkg::CNT_EMPTY;
            end
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            cnt_reg      <= pcc_pkg::CNT_EMPTY;
            first_x_reg  <= '0;
            first_y_reg  <= '0;
            prev_x_reg   <= '0;
            prev_y_reg   <= '0;
            first_ex_reg <= '0;
            first_ey_reg <= '0;
            prev_ex_reg  <= '0;
            prev_ey_reg  <= '0;
        end else begin
            if (en1) begin
                s1_valid_reg <= in_valid;
            end
            if (en2) begin
                s2_valid_reg <= s1_valid_reg;
            end
            cnt_reg      <= cnt_next;
            first_x_reg  <= first_x_next;
            first_y_reg  <= first_y_next;
            prev_x_reg   <= prev_x_next;
            prev_y_reg   <= prev_y_next;
            first_ex_reg <= first_ex_next;
            first_ey_reg <= first_ey_next;
            prev_ex_reg  <= prev_ex_next;
            prev_ey_reg  <= prev_ey_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (in_valid && en1) begin
            s1_x_reg    <= in_x;
            s1_y_reg    <= in_y;
            s1_last_reg <= in_last;
        end
        if (take) begin
            pe_x_reg         <= prev_ex_reg;
            pe_y_reg         <= prev_ey_reg;
            e_x_reg          <= ex;
            e_y_reg          <= ey;
            c_x_reg          <= cx;
            c_y_reg          <= cy;
            fe_x_reg         <= first_ex_reg;
            fe_y_reg         <= first_ey_reg;
            ctrl_reg.seen    <= cnt_reg;
            ctrl_reg.closing <= s1_last_reg;
        end
    end

    assign out_valid = s2_valid_reg;
    assign pe_x      = pe_x_reg;
    assign pe_y      = pe_y_reg;
    assign e_x       = e_x_reg;
    assign e_y       = e_y_reg;
    assign c_x       = c_x_reg;
    assign c_y       = c_y_reg;
    assign fe_x      = fe_x_reg;
    assign fe_y      = fe_y_reg;
    assign out_ctrl  = ctrl_reg;

endmodule

@@ hdl/pcc_cross_stage.sv @@
// registered partial products of the three cross products of one vertex
// depends on pcc_pkg
module pcc_cross_stage #(
    parameter int COORD_BITS = pcc_pkg::COORD_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic signed [COORD_BITS:0]      pe_x,
    input  logic signed [COORD_BITS:0]      pe_y,
    input  logic signed [COORD_BITS:0]      e_x,
    input  logic signed [COORD_BITS:0]      e_y,
    input  logic signed [COORD_BITS:0]      c_x,
    input  logic signed [COORD_BITS:0]      c_y,
    input  logic signed [COORD_BITS:0]      fe_x,
    input  logic signed [COORD_BITS:0]      fe_y,
    input  pcc_pkg::ctrl_t                  in_ctrl,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic signed [2*COORD_BITS+1:0]  main_l,
    output logic signed [2*COORD_BITS+1:0]  main_r,
    output logic signed [2*COORD_BITS+1:0]  a_l,
    output logic signed [2*COORD_BITS+1:0]  a_r,
    output logic signed [2*COORD_BITS+1:0]  b_l,
    output logic signed [2*COORD_BITS+1:0]  b_r,
    output pcc_pkg::ctrl_t                  out_ctrl
);

    localparam int PW = 2 * COORD_BITS + 2;

    logic                 valid_reg;
    logic signed [PW-1:0] main_l_reg, main_r_reg, a_l_reg, a_r_reg, b_l_reg, b_r_reg;
    pcc_pkg::ctrl_t       ctrl_reg;
    logic                 en;

    assign en       = !valid_reg || out_ready;
    assign in_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    // previous edge x new edge, new edge x closing edge, closing edge x first edge
    always_ff @(posedge aclk) begin
        if (in_valid && en) begin
            main_l_reg <= pe_x * e_y;
            main_r_reg <= pe_y * e_x;
            a_l_reg    <= e_x * c_y;
            a_r_reg    <= e_y * c_x;
            b_l_reg    <= c_x * fe_y;
            b_r_reg    <= c_y * fe_x;
            ctrl_reg   <= in_ctrl;
        end
    end

    assign out_valid = valid_reg;
    assign main_l    = main_l_reg;
    assign main_r    = main_r_reg;
    assign a_l       = a_l_reg;
    assign a_r       = a_r_reg;
    assign b_l       = b_l_reg;
    assign b_r       = b_r_reg;
    assign out_ctrl  = ctrl_reg;

endmodule

@@ hdl/pcc_sign_stage.sv @@
// turn signs, mismatch tracking and the registered convexity result
// depends on pcc_pkg
module pcc_sign_stage #(
    parameter int COORD_BITS = pcc_pkg::COORD_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic signed [2*COORD_BITS+1:0]  main_l,
    input  logic signed [2*COORD_BITS+1:0]  main_r,
    input  logic signed [2*COORD_BITS+1:0]  a_l,
    input  logic signed [2*COORD_BITS+1:0]  a_r,
    input  logic signed [2*COORD_BITS+1:0]  b_l,
    input  logic signed [2*COORD_BITS+1:0]  b_r,
    input  pcc_pkg::ctrl_t                  in_ctrl,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            out_convex
);

    logic out_valid_reg, out_valid_next;
    logic convex_reg;
    logic first_sign_reg, first_sign_next;
    logic mismatch_reg, mismatch_next;
    logic go, has_turns;
    logic s_main, s_a, s_b;
    logic convex_val;

    // non-closing vertices never wait on the result register
    assign in_ready  = !in_ctrl.closing || !out_valid_reg || out_ready;
    assign go        = in_valid && in_ready;
    assign has_turns = (in_ctrl.seen == pcc_pkg::CNT_TWO) || (in_ctrl.seen == pcc_pkg::CNT_MANY);

    // a turn is non-negative when its cross product is at least zero
    assign s_main = main_l >= main_r;
    assign s_a    = a_l >= a_r;
    assign s_b    = b_l >= b_r;

    // turn sign bookkeeping
    always_comb begin
        first_sign_next = first_sign_reg;
        mismatch_next   = mismatch_reg;
        convex_val      = 1'b1;
        if (go) begin
            if (in_ctrl.seen == pcc_pkg::CNT_TWO) begin
                first_sign_next = s_main;
            end else if (in_ctrl.seen == pcc_pkg::CNT_MANY && s_main != first_sign_reg) begin
                mismatch_next = 1'b1;
            end
            if (in_ctrl.closing) begin
                // the two turns around the closing edge
                if (has_turns) begin
                    if (s_a != first_sign_next || s_b != first_sign_next) begin
                        mismatch_next = 1'b1;
                    end
                    convex_val = !mismatch_next;
                end
                first_sign_next = 1'b0;
                mismatch_next   = 1'b0;
            end
        end
    end

    // result register valid
    always_comb begin
        out_valid_next = out_valid_reg;
        if (go && in_ctrl.closing) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            first_sign_reg <= 1'b0;
            mismatch_reg   <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            first_sign_reg <= first_sign_next;
            mismatch_reg   <= mismatch_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (go && in_ctrl.closing) begin
            convex_reg <= convex_val;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_convex = convex_reg;

endmodule

@@ hdl/polygon_convexity_checker_top.sv @@
// Polygon convexity checker: vertices stream in one per transaction, s_tlast marks the
// final vertex, and one result (m_tdata[0] = 1 when convex) follows each closed polygon.
// One vertex is accepted every cycle while s_tready is high; m_tvalid rises once the closing
// vertex has passed the four register stages (input, edge differences, cross-product
// multipliers, sign compare), the first of which loads on the edge that accepts it.
// Only a held result stalls the input, and only once a later closing vertex reaches the
// sign stage. Collinear turns count as non-negative; polygons of one or two vertices
// report convex.
// depends on pcc_pkg, pcc_edge_stage, pcc_cross_stage, pcc_sign_stage
module polygon_convexity_checker_top #(
    parameter int COORD_BITS = pcc_pkg::COORD_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [pcc_pkg::S_TDATA_W-1:0]   s_tdata,   // [15:0] vertex_x, [31:16] vertex_y
    input  logic                            s_tlast,   // closes_polygon
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [pcc_pkg::M_TDATA_W-1:0]   m_tdata    // [0] is_convex, [7:1] zero
);

    localparam int EW = COORD_BITS + 1;
    localparam int PW = 2 * COORD_BITS + 2;

    logic [COORD_BITS-1:0] vx, vy;
    logic                  e_valid, e_ready, c_valid, c_ready;
    logic signed [EW-1:0]  pe_x, pe_y, e_x, e_y, c_x, c_y, fe_x, fe_y;
    logic signed [PW-1:0]  main_l, main_r, a_l, a_r, b_l, b_r;
    pcc_pkg::ctrl_t        e_ctrl, c_ctrl;
    logic                  convex;

    // only the low coordinate bits take part
    assign vx = COORD_BITS'(s_tdata[pcc_pkg::VERTEX_W-1:0]);
    assign vy = COORD_BITS'(s_tdata[2*pcc_pkg::VERTEX_W-1:pcc_pkg::VERTEX_W]);

    pcc_edge_stage #(.COORD_BITS(COORD_BITS)) u_edge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_x      (vx),
        .in_y      (vy),
        .in_last   (s_tlast),
        .out_valid (e_valid),
        .out_ready (e_ready),
        .pe_x      (pe_x),
        .pe_y      (pe_y),
        .e_x       (e_x),
        .e_y       (e_y),
        .c_x       (c_x),
        .c_y       (c_y),
        .fe_x      (fe_x),
        .fe_y      (fe_y),
        .out_ctrl  (e_ctrl)
    );

    pcc_cross_stage #(.COORD_BITS(COORD_BITS)) u_cross (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (e_valid),
        .in_ready  (e_ready),
        .pe_x      (pe_x),
        .pe_y      (pe_y),
        .e_x       (e_x),
        .e_y       (e_y),
        .c_x       (c_x),
        .c_y       (c_y),
        .fe_x      (fe_x),
        .fe_y      (fe_y),
        .in_ctrl   (e_ctrl),
        .out_valid (c_valid),
        .out_ready (c_ready),
        .main_l    (main_l),
        .main_r    (main_r),
        .a_l       (a_l),
        .a_r       (a_r),
        .b_l       (b_l),
        .b_r       (b_r),
        .out_ctrl  (c_ctrl)
    );

    pcc_sign_stage #(.COORD_BITS(COORD_BITS)) u_sign (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (c_valid),
        .in_ready   (c_ready),
        .main_l     (main_l),
        .main_r     (main_r),
        .a_l        (a_l),
        .a_r        (a_r),
        .b_l        (b_l),
        .b_r        (b_r),
        .in_ctrl    (c_ctrl),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_convex (convex)
    );

    assign m_tdata = {{(pcc_pkg::M_TDATA_W-1){1'b0}}, convex};

endmodule

@@ hdl/pcc_checker.sv @@
// port-level assertions for the polygon convexity checker, bound to the top level
// depends on polygon_convexity_checker_top_defines.svh
`include "polygon_convexity_checker_top_defines.svh"

module pcc_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          s_tlast,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [pcc_pkg::M_TDATA_W-1:0] m_tdata
);

    // a stalled result holds its value
    `PCC_ASSERT_NEXT(a_result_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

    // padding bits of the result stay zero
    `PCC_ASSERT_SAME(a_result_pad, m_tvalid, m_tdata[pcc_pkg::M_TDATA_W-1:1] == '0, "result padding not zero")

    // an open result side never blocks vertices
    `PCC_ASSERT_SAME(a_no_false_stall, m_tready, s_tready, "input stalled with result side ready")

    // a closing vertex yields a result when the result side stays ready while it passes down the pipeline
    `PCC_ASSERT_NEXT(a_close_latency, s_tvalid && s_tready && s_tlast ##1 m_tready ##1 m_tready ##1 m_tready, m_tvalid, "no result after closing vertex")

endmodule

bind polygon_convexity_checker_top pcc_checker u_pcc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
